@@ rtl/assert_macros.svh @@
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock
`define PCRO_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent implies consequent on the next clock
`define PCRO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pcro_pkg.sv @@
`default_nettype none
package pcro_pkg;
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_W = 32;
    localparam int SUM_W = 38;
    localparam int CNT_W = 7;

    typedef struct packed {
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
        logic signed [COORD_W-1:0] in_z;
        logic                      last_point;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      last_result;
        logic                      overflow;
    } t_out;

    typedef struct packed {
        logic                    bank;
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic signed [SUM_W-1:0] sum_z;
        logic [CNT_W-1:0]        count;
        logic                    dropped;
    } t_job;

    typedef struct packed {
        logic                   en;
        logic                   bank;
        logic [CNT_W-1:0]       idx;
        logic [3*COORD_W-1:0]   data;
    } t_wr;
endpackage
`default_nettype wire

@@ rtl/point_cluster_radial_offset.sv @@
// point cluster radial offset
// input channel: i_valid / o_ready with i_data (x, y, z in signed Q15.16, last_point).
// points are stored and summed, one transfer per cycle while o_ready is high.
// the transfer marked last closes the cluster and hands it to the processing
// engine through a two-entry job queue; the point store has two banks so the
// next cluster can load while the previous one is still being emitted. points
// beyond MAX_POINTS are dropped and every result of that cluster carries overflow.
// output channel: o_valid / i_ready with o_data, one result per stored point in
// load order, last_result on the final one.
// per cluster the engine takes the job and divides the sums for the centroid,
// then per point it runs the normalize shifter (up to 29 steps), the 32-step
// square root and the 32-step divide; squares and distance products share one
// 32x32 multiplier. a point on the centroid is emitted unchanged. the job then retires.
// o_ready falls only when both store banks hold clusters not yet emitted.
// a stalled receiver holds the output register; the engine finishes the next
// point and waits for the register to free up.
// i_cfg_wr_en writes offset_distance; write it only while the block is idle.
// reset (i_rst_n low, synchronous) clears the input sums and count, the queue,
// the engine state, o_valid and the offset distance; store contents are not cleared.
`default_nettype none
module point_cluster_radial_offset #(
    parameter int MAX_POINTS = pcro_pkg::MAX_POINTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire pcro_pkg::t_in      i_data,
    output logic                    o_ready,
    output logic                    o_valid,
    output pcro_pkg::t_out          o_data,
    input  wire logic               i_ready,
    input  wire logic               i_cfg_wr_en,
    input  wire logic signed [31:0] i_cfg_data
);
    logic signed [31:0] r_dist;
    logic               w_full, w_empty, w_push, w_pop;
    pcro_pkg::t_job     w_job_in, w_job_out;
    pcro_pkg::t_wr      w_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= '0;
        end else if (i_cfg_wr_en) begin
            r_dist <= i_cfg_data;
        end
    end

    pcro_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_ready (o_ready),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job_in),
        .o_wr    (w_wr)
    );

    pcro_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    pcro_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_empty (w_empty),
        .i_job   (w_job_out),
        .o_pop   (w_pop),
        .i_dist  (r_dist),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_ready (i_ready)
    );
endmodule
`default_nettype wire

@@ rtl/pcro_front.sv @@
`default_nettype none
`include "assert_macros.svh"
module pcro_front #(
    parameter int MAX_POINTS = pcro_pkg::MAX_POINTS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire pcro_pkg::t_in i_data,
    output logic              o_ready,
    input  wire logic         i_full,
    output logic              o_push,
    output pcro_pkg::t_job    o_job,
    output pcro_pkg::t_wr     o_wr
);
    localparam int SW = pcro_pkg::SUM_W;
    localparam int CW = pcro_pkg::CNT_W;

    logic [CW-1:0]        r_cnt, n_cnt;
    logic signed [SW-1:0] r_sx, r_sy, r_sz, n_sx, n_sy, n_sz;
    logic                 r_drop, n_drop, r_bank;
    logic                 w_acc, w_room;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && !i_full;
    assign w_room  = r_cnt < CW'(MAX_POINTS);

    always_comb begin
        n_sx   = r_sx;
        n_sy   = r_sy;
        n_sz   = r_sz;
        n_cnt  = r_cnt;
        n_drop = r_drop;
        if (w_room) begin
            n_sx  = r_sx + {{(SW-32){i_data.in_x[31]}}, i_data.in_x};
            n_sy  = r_sy + {{(SW-32){i_data.in_y[31]}}, i_data.in_y};
            n_sz  = r_sz + {{(SW-32){i_data.in_z[31]}}, i_data.in_z};
            n_cnt = r_cnt + CW'(1);
        end else begin
            n_drop = 1'b1;
        end
    end

    assign o_wr.en   = w_acc && w_room;
    assign o_wr.bank = r_bank;
    assign o_wr.idx  = r_cnt;
    assign o_wr.data = {i_data.in_x, i_data.in_y, i_data.in_z};

    assign o_push        = w_acc && i_data.last_point;
    assign o_job.bank    = r_bank;
    assign o_job.sum_x   = n_sx;
    assign o_job.sum_y   = n_sy;
    assign o_job.sum_z   = n_sz;
    assign o_job.count   = n_cnt;
    assign o_job.dropped = n_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_sx   <= '0;
            r_sy   <= '0;
            r_sz   <= '0;
            r_drop <= 1'b0;
            r_bank <= 1'b0;
        end else if (w_acc) begin
            if (i_data.last_point) begin
                r_cnt  <= '0;
                r_sx   <= '0;
                r_sy   <= '0;
                r_sz   <= '0;
                r_drop <= 1'b0;
                r_bank <= !r_bank;
            end else begin
                r_cnt  <= n_cnt;
                r_sx   <= n_sx;
                r_sy   <= n_sy;
                r_sz   <= n_sz;
                r_drop <= n_drop;
            end
        end
    end

    `PCRO_ASSERT_NEXT(a_push_clears, i_clk, i_rst_n, o_push, r_cnt == '0 && !r_drop, "accumulator not cleared after cluster end")
    `PCRO_ASSERT(a_count_bound, i_clk, i_rst_n, r_cnt <= CW'(MAX_POINTS), "point count beyond store depth")
endmodule
`default_nettype wire

@@ rtl/pcro_fifo.sv @@
`default_nettype none
`include "assert_macros.svh"
module pcro_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pcro_pkg::t_job i_job,
    input  wire logic          i_pop,
    output pcro_pkg::t_job     o_job,
    output logic               o_full,
    output logic               o_empty
);
    pcro_pkg::t_job r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_count;

    assign o_job   = r_mem[r_rp];
    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    `PCRO_ASSERT(a_no_push_full, i_clk, i_rst_n, !(i_push && r_count == 2'd2), "push into full queue")
    `PCRO_ASSERT(a_no_pop_empty, i_clk, i_rst_n, !(i_pop && r_count == 2'd0), "pop from empty queue")
endmodule
`default_nettype wire

@@ rtl/pcro_back.sv @@
`default_nettype none
`include "assert_macros.svh"
module pcro_back #(
    parameter int MAX_POINTS = pcro_pkg::MAX_POINTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pcro_pkg::t_wr       i_wr,
    input  wire logic                i_empty,
    input  wire pcro_pkg::t_job      i_job,
    output logic                     o_pop,
    input  wire logic signed [31:0]  i_dist,
    output logic                     o_valid,
    output pcro_pkg::t_out           o_data,
    input  wire logic                i_ready
);
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int AW = IW + 1;
    localparam int SW = pcro_pkg::SUM_W;
    localparam int CW = pcro_pkg::CNT_W;

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_CDIV = 4'd1;
    localparam logic [3:0] B_RD   = 4'd2;
    localparam logic [3:0] B_RW   = 4'd3;
    localparam logic [3:0] B_NORM = 4'd4;
    localparam logic [3:0] B_SQ   = 4'd5;
    localparam logic [3:0] B_SQRT = 4'd6;
    localparam logic [3:0] B_MUL  = 4'd7;
    localparam logic [3:0] B_DIV  = 4'd8;
    localparam logic [3:0] B_FIN  = 4'd9;
    localparam logic [3:0] B_OUT  = 4'd10;
    localparam logic [3:0] B_DONE = 4'd11;

    logic [95:0] r_mem [2**AW];
    logic [95:0] r_rd;

    logic [3:0]           r_state;
    logic [CW-1:0]        r_cnt, r_k;
    logic                 r_bank, r_drop;
    logic [5:0]           r_it;
    logic [1:0]           r_step;
    logic                 r_sgn [3];
    logic [SW-1:0]        r_dn [3];
    logic [CW:0]          r_drem [3];
    logic signed [32:0]   r_c [3];
    logic signed [31:0]   r_p [3];
    logic [32:0]          r_a [3];
    logic                 r_neg [3];
    logic [62:0]          r_q, r_root, r_bit;
    logic [61:0]          r_prod;
    logic [30:0]          r_n;
    logic [30:0]          r_rem [3];
    logic [31:0]          r_lo [3];
    logic signed [31:0]   r_res [3];
    logic                 r_ov;
    pcro_pkg::t_out       r_od;

    logic [AW-1:0]        w_raddr;
    logic [32:0]          w_m, w_sel;
    logic [31:0]          w_ma, w_mb, w_dm;
    logic [63:0]          w_mul;
    logic [62:0]          w_t;
    logic                 w_load, w_last;
    logic signed [31:0]   w_pin [3];
    logic signed [33:0]   w_d [3];
    logic [32:0]          w_ain [3];
    logic [32:0]          w_min;
    logic [SW-1:0]        w_abs [3];
    logic signed [SW-1:0] w_sum [3];

    assign w_raddr = {r_bank, r_k[IW-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.bank, i_wr.idx[IW-1:0]}] <= i_wr.data;
        end
        r_rd <= r_mem[w_raddr];
    end

    assign w_sum[0] = i_job.sum_x;
    assign w_sum[1] = i_job.sum_y;
    assign w_sum[2] = i_job.sum_z;
    assign w_pin[0] = r_rd[95:64];
    assign w_pin[1] = r_rd[63:32];
    assign w_pin[2] = r_rd[31:0];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_abs[j] = w_sum[j][SW-1] ? SW'(-w_sum[j]) : SW'(w_sum[j]);
            w_d[j]   = {{2{w_pin[j][31]}}, w_pin[j]} - {r_c[j][32], r_c[j]};
            w_ain[j] = w_d[j][33] ? 33'(-w_d[j]) : w_d[j][32:0];
        end
        w_min = w_ain[0];
        if (w_ain[1] > w_min) w_min = w_ain[1];
        if (w_ain[2] > w_min) w_min = w_ain[2];
        w_m = r_a[0];
        if (r_a[1] > w_m) w_m = r_a[1];
        if (r_a[2] > w_m) w_m = r_a[2];
    end

    assign w_dm  = i_dist[31] ? 32'(-i_dist) : i_dist;
    assign w_sel = (r_step == 2'd0) ? r_a[0] : (r_step == 2'd1) ? r_a[1] : r_a[2];
    assign w_ma  = w_sel[31:0];
    assign w_mb  = (r_state == B_SQ) ? w_sel[31:0] : w_dm;
    assign w_mul = w_ma * w_mb;
    assign w_t   = r_root + r_bit;

    assign w_load = !r_ov || i_ready;
    assign w_last = (r_k + CW'(1)) == r_cnt;
    assign o_pop  = r_state == B_DONE;
    assign o_valid = r_ov;
    assign o_data  = r_od;

    always_ff @(posedge i_clk) begin
        logic [CW:0]   v_r2;
        logic [31:0]   v_rem2;
        logic [31:0]   v_q;
        logic signed [33:0] v_s, v_o;
        case (r_state)
            B_IDLE: begin
                r_cnt  <= i_job.count;
                r_bank <= i_job.bank;
                r_drop <= i_job.dropped;
                r_it   <= '0;
                r_k    <= '0;
                for (int j = 0; j < 3; j++) begin
                    r_sgn[j]  <= w_sum[j][SW-1];
                    r_dn[j]   <= w_abs[j];
                    r_drem[j] <= '0;
                end
            end
            B_CDIV: begin
                if (r_it != 6'(SW)) begin
                    r_it <= r_it + 6'd1;
                    for (int j = 0; j < 3; j++) begin
                        v_r2 = {r_drem[j][CW-1:0], r_dn[j][SW-1]};
                        if (v_r2 >= {1'b0, r_cnt}) begin
                            r_drem[j] <= v_r2 - {1'b0, r_cnt};
                            r_dn[j]   <= {r_dn[j][SW-2:0], 1'b1};
                        end else begin
                            r_drem[j] <= v_r2;
                            r_dn[j]   <= {r_dn[j][SW-2:0], 1'b0};
                        end
                    end
                end else begin
                    for (int j = 0; j < 3; j++) begin
                        r_c[j] <= r_sgn[j] ? -$signed(r_dn[j][32:0]) : $signed(r_dn[j][32:0]);
                    end
                end
            end
            B_RW: begin
                for (int j = 0; j < 3; j++) begin
                    r_p[j]   <= w_pin[j];
                    r_a[j]   <= w_ain[j];
                    r_neg[j] <= w_d[j][33];
                    r_res[j] <= w_pin[j];
                end
            end
            B_NORM: begin
                if (|w_m[32:30]) begin
                    for (int j = 0; j < 3; j++) r_a[j] <= r_a[j] >> 1;
                end else if (w_m[32:29] == 4'd0) begin
                    for (int j = 0; j < 3; j++) r_a[j] <= r_a[j] << 1;
                end else begin
                    r_step <= 2'd0;
                    r_q    <= '0;
                end
            end
            B_SQ: begin
                r_prod <= w_mul[61:0];
                if (r_step != 2'd0) r_q <= r_q + {1'b0, r_prod};
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_root <= '0;
                    r_bit  <= 63'd1 << 62;
                end
            end
            B_SQRT: begin
                if (r_bit == '0) begin
                    r_n    <= (r_root[30:0] == '0) ? 31'd1 : r_root[30:0];
                    r_step <= 2'd0;
                end else begin
                    if (r_q >= w_t) begin
                        r_q    <= r_q - w_t;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
            end
            B_MUL: begin
                r_prod <= w_mul[61:0];
                r_step <= r_step + 2'd1;
                r_it   <= '0;
                case (r_step)
                    2'd1: begin
                        r_rem[0] <= {1'b0, r_prod[61:32]};
                        r_lo[0]  <= r_prod[31:0];
                    end
                    2'd2: begin
                        r_rem[1] <= {1'b0, r_prod[61:32]};
                        r_lo[1]  <= r_prod[31:0];
                    end
                    2'd3: begin
                        r_rem[2] <= {1'b0, r_prod[61:32]};
                        r_lo[2]  <= r_prod[31:0];
                    end
                    default: begin
                    end
                endcase
            end
            B_DIV: begin
                r_it <= r_it + 6'd1;
                for (int j = 0; j < 3; j++) begin
                    v_rem2 = {r_rem[j], r_lo[j][31]};
                    if (v_rem2 >= {1'b0, r_n}) begin
                        r_rem[j] <= 31'(v_rem2 - {1'b0, r_n});
                        r_lo[j]  <= {r_lo[j][30:0], 1'b1};
                    end else begin
                        r_rem[j] <= v_rem2[30:0];
                        r_lo[j]  <= {r_lo[j][30:0], 1'b0};
                    end
                end
            end
            B_FIN: begin
                for (int j = 0; j < 3; j++) begin
                    v_q = r_lo[j];
                    v_s = (r_neg[j] ^ i_dist[31]) ? -$signed({2'b00, v_q})
                                                  : $signed({2'b00, v_q});
                    v_o = {{2{r_p[j][31]}}, r_p[j]} + v_s;
                    if (v_o[33:31] != 3'b000 && v_o[33:31] != 3'b111) begin
                        r_res[j] <= v_o[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                    end else begin
                        r_res[j] <= v_o[31:0];
                    end
                end
            end
            B_OUT: begin
                if (w_load) begin
                    r_od.out_x       <= r_res[0];
                    r_od.out_y       <= r_res[1];
                    r_od.out_z       <= r_res[2];
                    r_od.last_result <= w_last;
                    r_od.overflow    <= r_drop;
                    r_k              <= r_k + CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_state)
                B_IDLE: if (!i_empty) r_state <= B_CDIV;
                B_CDIV: begin
                    if (r_it == 6'(SW)) r_state <= (r_cnt == '0) ? B_DONE : B_RD;
                end
                B_RD: r_state <= B_RW;
                B_RW: r_state <= (w_min == '0) ? B_OUT : B_NORM;
                B_NORM: begin
                    if (!(|w_m[32:30]) && w_m[32:29] != 4'd0) r_state <= B_SQ;
                end
                B_SQ: if (r_step == 2'd3) r_state <= B_SQRT;
                B_SQRT: if (r_bit == '0) r_state <= B_MUL;
                B_MUL: if (r_step == 2'd3) r_state <= B_DIV;
                B_DIV: if (r_it == 6'd31) r_state <= B_FIN;
                B_FIN: r_state <= B_OUT;
                B_OUT: begin
                    if (w_load) begin
                        r_ov    <= 1'b1;
                        r_state <= w_last ? B_DONE : B_RD;
                    end
                end
                B_DONE: r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    `PCRO_ASSERT_NEXT(a_last_ends_job, i_clk, i_rst_n, r_state == B_OUT && w_load && w_last, r_state == B_DONE && r_ov && r_od.last_result, "cluster did not end after last result")
    `PCRO_ASSERT(a_pop_has_job, i_clk, i_rst_n, !(o_pop && i_empty), "job retired with empty queue")
endmodule
`default_nettype wire
